// File: src/pfdm_pkg.sv
package pfdm_pkg;

  localparam int RATE_W = 24;
  localparam int FREQ_W = 23;
  localparam int DUTY_W = 7;

  // 16 MHz core clock over a /1024 prescaler
  localparam logic [RATE_W-1:0] TICK_RATE_RESET = 24'd15625;
  localparam int DUTY_SCALE = 100;

  localparam int JOB_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUTY_W-1:0] duty_percent;
    logic              count_overflow;
  } result_t;

endpackage

// File: src/pfdm_front.sv
module pfdm_front #(
  parameter int CW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic          level,
  output logic          job_push,
  output logic [CW-1:0] job_high,
  output logic [CW:0]   job_period,
  output logic          job_sat
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0] CNT_ONE = {{(CW-1){1'b0}}, 1'b1};

  logic [1:0]    phase_r, phase_nxt;
  logic          prev_r, prev_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] high_r, high_nxt;
  logic          sat_r, sat_nxt;
  logic [CW-1:0] cnt_inc;
  logic          cnt_full;

  assign cnt_full   = (cnt_r == CNT_MAX);
  assign cnt_inc    = cnt_full ? cnt_r : cnt_r + CNT_ONE;
  assign job_high   = high_r;
  assign job_period = {1'b0, high_r} + {1'b0, cnt_r};
  assign job_sat    = sat_r;

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    high_nxt  = high_r;
    sat_nxt   = sat_r;
    job_push  = 1'b0;
    if (take) begin
      prev_nxt = level;
      case (phase_r)
        PH_HIGH: begin
          if (level) begin
            cnt_nxt = cnt_inc;
            sat_nxt = sat_r | cnt_full;
          end else begin
            high_nxt  = cnt_r;
            cnt_nxt   = CNT_ONE;
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          if (!level) begin
            cnt_nxt = cnt_inc;
            sat_nxt = sat_r | cnt_full;
          end else begin
            // period complete: hand off and restart on this edge
            job_push  = 1'b1;
            cnt_nxt   = CNT_ONE;
            high_nxt  = '0;
            sat_nxt   = 1'b0;
            phase_nxt = PH_HIGH;
          end
        end
        default: begin
          if (level && !prev_r) begin
            cnt_nxt   = CNT_ONE;
            high_nxt  = '0;
            sat_nxt   = 1'b0;
            phase_nxt = PH_HIGH;
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      prev_r  <= 1'b0;
      cnt_r   <= '0;
      high_r  <= '0;
      sat_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      high_r  <= high_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

// File: src/pfdm_fifo.sv
module pfdm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] A_ONE = AW'(1);
  localparam logic [CNTW-1:0] C_ONE = CNTW'(1);
  localparam logic [CNTW-1:0] C_FULL = CNTW'(DEPTH);

  logic [W-1:0]    mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == C_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == LAST) ? '0 : wp_r + A_ONE;
    if (do_pop)  rp_nxt = (rp_r == LAST) ? '0 : rp_r + A_ONE;
    if (do_push && !do_pop) cnt_nxt = cnt_r + C_ONE;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - C_ONE;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/pfdm_back.sv
module pfdm_back #(
  parameter int CW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pfdm_pkg::RATE_W-1:0] tick_rate,
  input  logic                        job_avail,
  input  logic [CW-1:0]               job_high,
  input  logic [CW:0]                 job_period,
  input  logic                        job_sat,
  output logic                        job_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pfdm_pkg::result_t           result
);

  // dividend width covers tick_rate and high*100
  localparam int DW = (CW + 7 > pfdm_pkg::RATE_W) ? CW + 7 : pfdm_pkg::RATE_W;
  localparam int SW = $clog2(DW);
  localparam logic [SW-1:0] STEP_LAST = SW'(DW - 1);
  localparam logic [SW-1:0] STEP_ONE = SW'(1);

  logic          busy_r, busy_nxt;
  logic          ov_r, ov_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [CW:0]   div_r, div_nxt;
  logic [DW-1:0] fa_r, fa_nxt;
  logic [CW:0]   fr_r, fr_nxt;
  logic [DW-1:0] da_r, da_nxt;
  logic [CW:0]   dr_r, dr_nxt;
  logic          sat_r, sat_nxt;
  pfdm_pkg::result_t res_r, res_nxt;

  logic [CW+1:0] f_sh, d_sh, div_ext;
  logic          f_ge, d_ge;

  assign div_ext = {1'b0, div_r};
  assign f_sh = {fr_r, fa_r[DW-1]};
  assign d_sh = {dr_r, da_r[DW-1]};
  assign f_ge = (f_sh >= div_ext);
  assign d_ge = (d_sh >= div_ext);

  assign job_pop   = !busy_r && !ov_r && job_avail;
  assign out_valid = ov_r;
  assign result    = res_r;

  always_comb begin
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    step_nxt = step_r;
    div_nxt  = div_r;
    fa_nxt   = fa_r;
    fr_nxt   = fr_r;
    da_nxt   = da_r;
    dr_nxt   = dr_r;
    sat_nxt  = sat_r;
    res_nxt  = res_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (job_pop) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      div_nxt  = job_period;
      fa_nxt   = DW'(tick_rate);
      da_nxt   = DW'(job_high) * DW'(pfdm_pkg::DUTY_SCALE);
      fr_nxt   = '0;
      dr_nxt   = '0;
      sat_nxt  = job_sat;
    end else if (busy_r) begin
      // restoring division, one quotient bit per cycle on both lanes
      fr_nxt   = f_ge ? (CW+1)'(f_sh - div_ext) : f_sh[CW:0];
      dr_nxt   = d_ge ? (CW+1)'(d_sh - div_ext) : d_sh[CW:0];
      fa_nxt   = {fa_r[DW-2:0], f_ge};
      da_nxt   = {da_r[DW-2:0], d_ge};
      step_nxt = step_r + STEP_ONE;
      if (step_r == STEP_LAST) begin
        busy_nxt               = 1'b0;
        ov_nxt                 = 1'b1;
        res_nxt.frequency_hz   = fa_nxt[pfdm_pkg::FREQ_W-1:0];
        res_nxt.duty_percent   = da_nxt[pfdm_pkg::DUTY_W-1:0];
        res_nxt.count_overflow = sat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    fa_r  <= fa_nxt;
    fr_r  <= fr_nxt;
    da_r  <= da_nxt;
    dr_r  <= dr_nxt;
    sat_r <= sat_nxt;
    res_r <= res_nxt;
  end

endmodule

// File: src/pwm_frequency_duty_meter.sv
// PWM frequency and duty meter. Each input beat is one prescaled timer tick
// carrying the sampled pin level; one beat is taken per clock unless stalled.
// After the first rising edge the block counts high ticks to the falling
// edge and low ticks to the next rising edge, where it emits one result beat:
// frequency_hz = tick_rate / period and duty_percent = high*100 / period
// (both truncated), then restarts on that same edge. Counts saturate at
// 2^COUNT_WIDTH-1 and flag count_overflow. The tick counter front end runs at
// one beat per cycle while the queue has room; finished periods go through a
// two-entry queue to a shared-step restoring divider over a dividend of
// max(24, COUNT_WIDTH+7) bits (24 at the default). It loads a period, runs
// the division, then presents the out beat and holds its result until the
// out side takes it, and takes no new period before then. in_stall rises
// only while the queue is full, which happens only when periods shorter than
// the divider time arrive back to back or the out side stalls. tick_rate is
// written through the cfg channel (always ready) and should only be changed
// while no period is in flight; it resets to 15625.
module pwm_frequency_duty_meter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // tick input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_signal_level,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pfdm_pkg::FREQ_W-1:0] out_frequency_hz,
  output logic [pfdm_pkg::DUTY_W-1:0] out_duty_percent,
  output logic                        out_count_overflow,
  // tick_rate register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pfdm_pkg::RATE_W-1:0] cfg_data
);

  localparam int JW = 2 * COUNT_WIDTH + 2;

  logic [pfdm_pkg::RATE_W-1:0] tick_rate_r;
  logic                        take;
  logic                        q_full, q_empty;
  logic                        f_push;
  logic [COUNT_WIDTH-1:0]      f_high;
  logic [COUNT_WIDTH:0]        f_period;
  logic                        f_sat;
  logic [JW-1:0]               q_rdata;
  logic                        b_pop;
  pfdm_pkg::result_t           res;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign take      = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= pfdm_pkg::TICK_RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_rate_r <= cfg_data;
    end
  end

  pfdm_front #(.CW(COUNT_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .level      (in_signal_level),
    .job_push   (f_push),
    .job_high   (f_high),
    .job_period (f_period),
    .job_sat    (f_sat)
  );

  // queue word: {sat, period, high}
  pfdm_fifo #(.W(JW), .DEPTH(pfdm_pkg::JOB_QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_sat, f_period, f_high}),
    .pop   (b_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  pfdm_back #(.CW(COUNT_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_rate  (tick_rate_r),
    .job_avail  (!q_empty),
    .job_high   (q_rdata[COUNT_WIDTH-1:0]),
    .job_period (q_rdata[2*COUNT_WIDTH:COUNT_WIDTH]),
    .job_sat    (q_rdata[JW-1]),
    .job_pop    (b_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (res)
  );

  assign out_frequency_hz   = res.frequency_hz;
  assign out_duty_percent   = res.duty_percent;
  assign out_count_overflow = res.count_overflow;

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Counter width of the meter under test, and the top of its counts.
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  // Settle margin for the queue of two periods and the divider to go idle.
  localparam int SETTLE_CYCLES = 64;
  localparam int unsigned RANDOM_TICKS = 105;
  localparam logic [pfdm_pkg::RATE_W-1:0] RATE_TOP_OF_RANGE = 24'd16000000;

  localparam logic [1:0] SEEK_RISE = 2'd0;
  localparam logic [1:0] HIGH_SPAN = 2'd1;
  localparam logic [1:0] LOW_SPAN  = 2'd2;

  // One row of the directed plan: a run of ticks at one level. Where the first
  // tick of the run closes a period, the reading may be typed in by hand.
  typedef struct packed {
    logic                        level;
    logic [19:0]                 run;
    logic                        typed;
    logic [pfdm_pkg::FREQ_W-1:0] freq;
    logic [pfdm_pkg::DUTY_W-1:0] duty;
    logic                        ovf;
  } span_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_signal_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [pfdm_pkg::FREQ_W-1:0] out_frequency_hz;
  logic [pfdm_pkg::DUTY_W-1:0] out_duty_percent;
  logic out_count_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pfdm_pkg::RATE_W-1:0] cfg_data = '0;

  pwm_frequency_duty_meter #(
    .COUNT_WIDTH(CNT_W)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_signal_level    (in_signal_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frequency_hz   (out_frequency_hz),
    .out_duty_percent   (out_duty_percent),
    .out_count_overflow (out_count_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Directed plan, run at the reset tick_rate of 15625. The very first tick is
  // high, so it counts as a rising edge straight out of reset. Typed readings:
  //   high 1, low 1    -> period 2:   7812 Hz, 50 %
  //   high 1, low 101  -> period 102: 153 Hz, 0 % (duty floor)
  //   high 99, low 1   -> period 100: 156 Hz, 99 % (duty ceiling)
  //   high 1, low 2    -> period 3:   5208 Hz, 33 %
  // ---------------------------------------------------------------------------
  span_row_t edge_plan [14] = '{
    '{1'b1,   1, 1'b0,    0,  0, 1'b0},
    '{1'b0,   1, 1'b0,    0,  0, 1'b0},
    '{1'b1,   1, 1'b1, 7812, 50, 1'b0},
    '{1'b0, 101, 1'b0,    0,  0, 1'b0},
    '{1'b1,  99, 1'b1,  153,  0, 1'b0},
    '{1'b0,   1, 1'b0,    0,  0, 1'b0},
    '{1'b1,   1, 1'b1,  156, 99, 1'b0},
    '{1'b0,   2, 1'b0,    0,  0, 1'b0},
    '{1'b1,   2, 1'b1, 5208, 33, 1'b0},
    '{1'b0,   2, 1'b0,    0,  0, 1'b0},
    '{1'b1,   3, 1'b0,    0,  0, 1'b0},
    '{1'b0,   5, 1'b0,    0,  0, 1'b0},
    '{1'b1,   1, 1'b0,    0,  0, 1'b0},
    '{1'b0,   1, 1'b0,    0,  0, 1'b0}
  };

  // Short runs at the top rate, alternating levels and starting high: the
  // fastest reading (period 2) twice, then period 3 and period 4.
  int unsigned top_rate_runs [7] = '{1, 1, 1, 2, 1, 3, 2};

  // Meter state as the testbench tracks it.
  logic [pfdm_pkg::RATE_W-1:0] rate_setting = pfdm_pkg::TICK_RATE_RESET;
  logic                        last_level = 1'b0;
  logic [1:0]                  span = SEEK_RISE;
  logic [CNT_W-1:0]            ticks = '0;
  logic [CNT_W-1:0]            hi_ticks = '0;
  logic                        saturated = 1'b0;

  pfdm_pkg::result_t expected_readings [$];

  int unsigned send_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned send_calm = 0;
  int unsigned stall_calm = 0;

  int unsigned ticks_sent = 0;
  int unsigned readings_checked = 0;
  int unsigned rate_writes = 0;
  int unsigned mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Random idling with occasional calm stretches, so bursts with no gaps at
  // all also reach the block in every idling phase.
  function automatic bit idle_now(input int unsigned pct, inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 63) == 0)
      calm = $urandom_range(8, 40);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void bump_count();
    if (ticks == CNT_MAX)
      saturated = 1'b1;
    else
      ticks = ticks + 1'b1;
  endfunction

  function automatic void open_span();
    ticks = CNT_W'(1);
    hi_ticks = '0;
    saturated = 1'b0;
    span = HIGH_SPAN;
  endfunction

  // Advances the tracked meter by one tick; returns 1 with the reading when a
  // rising edge closes a full period.
  function automatic bit predict_reading(input logic lvl, output pfdm_pkg::result_t rd);
    logic [CNT_W:0] period;
    bit done;
    rd = '0;
    done = 1'b0;
    case (span)
      HIGH_SPAN: begin
        if (lvl) begin
          bump_count();
        end else begin
          hi_ticks = ticks;
          ticks = CNT_W'(1);
          span = LOW_SPAN;
        end
      end
      LOW_SPAN: begin
        if (!lvl) begin
          bump_count();
        end else begin
          // both counts are at least 1, so period is never zero
          period = {1'b0, hi_ticks} + {1'b0, ticks};
          rd.frequency_hz = pfdm_pkg::FREQ_W'(32'(rate_setting) / 32'(period));
          rd.duty_percent = pfdm_pkg::DUTY_W'((32'(hi_ticks) * pfdm_pkg::DUTY_SCALE)
                                              / 32'(period));
          rd.count_overflow = saturated;
          done = 1'b1;
          open_span();
        end
      end
      default: begin
        if (lvl && !last_level)
          open_span();
        else
          span = SEEK_RISE;
      end
    endcase
    last_level = lvl;
    return done;
  endfunction

  // Offers one tick beat and holds it until taken. The reading is predicted
  // at the edge where the beat is accepted.
  task automatic send_tick(input logic lvl, input bit typed = 1'b0,
                           input pfdm_pkg::result_t typed_rd = '0);
    pfdm_pkg::result_t rd;
    while (idle_now(send_gap_pct, send_calm)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_signal_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    if (predict_reading(lvl, rd))
      expected_readings.push_back(typed ? typed_rd : rd);
  endtask

  // tick_rate write; the port is always ready but the handshake is honored.
  task automatic load_rate(input logic [pfdm_pkg::RATE_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rate_setting = r;
    rate_writes++;
  endtask

  // Stop offering ticks, let every pending reading come out, then give the
  // divider time to go fully idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly short spans, now and then a longer one.
  function automatic int unsigned span_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return $urandom_range(1, 4);
    else if (pick < 95)
      return $urandom_range(5, 20);
    return $urandom_range(21, 300);
  endfunction

  // Mostly clean pulses of random shape; the rest is random level noise,
  // which gives glitches, single-tick spans and back-to-back edges.
  task automatic random_waveform(input int unsigned n);
    int unsigned first, hi, lo, k;
    first = ticks_sent;
    while (ticks_sent - first < n) begin
      if ($urandom_range(0, 99) < 85) begin
        hi = span_len();
        lo = span_len();
        repeat (hi) send_tick(1'b1);
        repeat (lo) send_tick(1'b0);
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) send_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic waveform_phase(input logic [pfdm_pkg::RATE_W-1:0] r,
                                input int unsigned gap_pct,
                                input int unsigned stall_pct);
    settle();
    load_rate(r);
    send_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    random_waveform(RANDOM_TICKS);
  endtask

  // Result side: random stall, and every accepted beat is checked against the
  // oldest predicted reading.
  always @(posedge clk) begin
    pfdm_pkg::result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_frequency_hz, out_duty_percent, out_count_overflow};
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading: freq %0d duty %0d ovf %0b", $time,
                 got.frequency_hz, got.duty_percent, got.count_overflow);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (got.frequency_hz !== want.frequency_hz)
          $display("%0t: frequency_hz expected %0d, got %0d", $time,
                   want.frequency_hz, got.frequency_hz);
        if (got.duty_percent !== want.duty_percent)
          $display("%0t: duty_percent expected %0d, got %0d", $time,
                   want.duty_percent, got.duty_percent);
        if (got.count_overflow !== want.count_overflow)
          $display("%0t: count_overflow expected %0b, got %0b", $time,
                   want.count_overflow, got.count_overflow);
        if (got !== want)
          mismatches++;
      end
    end
    out_stall <= idle_now(out_stall_pct, stall_calm);
  end

  initial begin
    logic lvl;
    pfdm_pkg::result_t typed_rd;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edges at the reset rate, no idling on either side.
    foreach (edge_plan[i]) begin
      typed_rd = {edge_plan[i].freq, edge_plan[i].duty, edge_plan[i].ovf};
      send_tick(edge_plan[i].level, edge_plan[i].typed, typed_rd);
      repeat (edge_plan[i].run - 1) send_tick(edge_plan[i].level);
    end

    // Short periods at the top of the tick_rate range, no idling.
    settle();
    load_rate(RATE_TOP_OF_RANGE);
    lvl = 1'b1;
    foreach (top_rate_runs[i]) begin
      repeat (top_rate_runs[i]) send_tick(lvl);
      lvl = ~lvl;
    end

    // Random waveforms under each idling mix and across the rate extremes,
    // including the out-of-range zero rate and the all-ones register value.
    waveform_phase(24'd1, 69, 0);
    waveform_phase('1, 0, 69);
    waveform_phase('0, 33, 33);
    waveform_phase(pfdm_pkg::RATE_W'($urandom_range(1, 16000000)), 33, 33);
    waveform_phase(pfdm_pkg::TICK_RATE_RESET, 0, 0);
    settle();

    $display("Sent %0d ticks and checked %0d readings over %0d tick_rate writes,",
             ticks_sent, readings_checked, rate_writes);
    $display("covering duty extremes, the fastest reading and rates from 0 to all ones.");
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Safety net: the slowest legal run is well under a third of this.
  initial begin
    #2_000_000;
    $display("Timeout with %0d readings still pending", expected_readings.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
